>>> hw/rtl/pbmhp_pkg.sv
package pbmhp_pkg;

    // Default sizes of the dimension accumulators and of the byte counter
    localparam int DIM_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 32;

    // Fixed widths of the stream words
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;
    localparam int IMG_DIM_W   = 16;
    localparam int STATUS_W    = 3;

    // Characters the header grammar looks at
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // A file this long or shorter is reported as too short
    localparam int SHORT_LIMIT = 7;

    typedef enum logic [3:0] {
        PH_MAGIC_P    = 4'd0,
        PH_MAGIC_4    = 4'd1,
        PH_MAGIC_NL   = 4'd2,
        PH_LINE_START = 4'd3,
        PH_COMMENT    = 4'd4,
        PH_WIDTH      = 4'd5,
        PH_HEIGHT     = 4'd6,
        PH_DATA       = 4'd7
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_MAGIC    = 3'd2,
        ST_SEP      = 3'd3,
        ST_TRUNC    = 3'd4,
        ST_MISMATCH = 3'd5,
        ST_OVERFLOW = 3'd6
    } status_t;

    // One result word before packing onto the output stream
    typedef struct packed {
        logic                 pixel_valid;
        logic [7:0]           pixel_byte;
        logic                 done_res;
        status_t              status;
        logic [IMG_DIM_W-1:0] img_width;
        logic [IMG_DIM_W-1:0] img_height;
    } res_t;

endpackage

>>> hw/rtl/pbm_p4_header_parser_unit.sv
// Binary PBM (P4) header parser.
//
// Input stream (s_*): one file byte per word in s_tdata, s_tlast on the final
// byte of the file. The parser checks the magic "P4\n", skips '#' comment lines,
// reads the decimal width (ended by a space) and height (ended by a newline),
// then passes every following byte through as bitmap data.
// Output stream (m_*): exactly one word per input word. m_tuser flags a bitmap
// byte; m_tlast repeats the last-byte mark and carries the verdict: status,
// and the parsed width and height when status is ok.
// Each result word is registered in the output register or the skid register.
// Throughput: one byte per cycle while s_tready is high; all parsing is a single
// pass of logic between the parse state registers and the output register.
// A two-entry output stage (output register plus skid register) lets the
// parser keep taking bytes while a result waits; s_tready drops only when
// both entries are full, and comes back once m_tready takes one.
// Reset clears the parse state to "expect P" and empties both output entries.
// After each last byte the parse state returns to that same state, so the
// next word starts a new file.
module pbm_p4_header_parser_unit
    import pbmhp_pkg::*;
#(
    parameter int DIM_BITS   = DIM_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] in_byte
    input  logic                   s_tlast,   // last_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] pixel_byte, [10:8] status,
                                              // [26:11] img_width, [42:27] img_height,
                                              // [47:43] zero
    output logic                   m_tuser,   // pixel_valid
    output logic                   m_tlast    // done_res
);

    // Row bytes: ceil(width / 8), at most 2^(DIM_BITS-3)
    localparam int RB_W  = DIM_BITS - 2;
    // Running product row_bytes * height, bounded by the dimension limits
    localparam int PR_W  = 2 * DIM_BITS - 2;
    // Header length plus product, wide enough to see a carry past COUNT_BITS
    localparam int SUM_W = ((PR_W > COUNT_BITS) ? PR_W : COUNT_BITS) + 1;
    localparam int ACC_W = DIM_BITS + 4;

    // Parse state
    phase_t                phase_reg,          phase_next;
    logic [DIM_BITS-1:0]   width_acc_reg,      width_acc_next;
    logic [DIM_BITS-1:0]   height_acc_reg,     height_acc_next;
    logic [PR_W-1:0]       prod_reg,           prod_next;
    logic [COUNT_BITS-1:0] total_count_reg,    total_count_next;
    logic [COUNT_BITS-1:0] expected_total_reg, expected_total_next;
    status_t               error_code_reg,     error_code_next;

    // Output stage
    res_t out_reg,  skid_reg;
    logic out_valid_reg, skid_valid_reg;

    res_t res;
    logic s_accept;
    logic out_free;

    logic [7:0]       in_byte;
    logic             is_digit;
    logic [3:0]       digit;
    logic [ACC_W-1:0] width_ext;
    logic [ACC_W-1:0] height_ext;
    logic [ACC_W-1:0] width_dig;
    logic [ACC_W-1:0] height_dig;
    logic             width_ovf;
    logic             height_ovf;
    logic [RB_W-1:0]  row_bytes;
    logic [RB_W+3:0]  rb_dig;
    logic [PR_W+3:0]  prod_dig;
    logic             count_sat;
    logic [COUNT_BITS-1:0] count_inc;
    logic [SUM_W-1:0] total_sum;
    logic             total_ovf;

    assign in_byte  = s_tdata[7:0];
    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Decimal digit accumulation: acc * 10 + digit as two shifts and adds
    assign is_digit   = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign digit      = in_byte[3:0];
    assign width_ext  = ACC_W'(width_acc_reg);
    assign height_ext = ACC_W'(height_acc_reg);
    assign width_dig  = (width_ext << 3) + (width_ext << 1) + ACC_W'(digit);
    assign height_dig = (height_ext << 3) + (height_ext << 1) + ACC_W'(digit);
    assign width_ovf  = (width_dig[ACC_W-1:DIM_BITS] != '0);
    assign height_ovf = (height_dig[ACC_W-1:DIM_BITS] != '0);

    // Keep row_bytes * height current while height digits arrive, so that the
    // closing newline needs only one add and compare against the count limit.
    assign row_bytes = RB_W'(((DIM_BITS+1)'(width_acc_reg) + (DIM_BITS+1)'(7)) >> 3);
    assign rb_dig    = (RB_W+4)'(row_bytes) * (RB_W+4)'(digit);
    assign prod_dig  = ((PR_W+4)'(prod_reg) << 3) + ((PR_W+4)'(prod_reg) << 1)
                       + (PR_W+4)'(rb_dig);

    // Byte counter saturates at its top value; a byte arriving there is an overflow
    assign count_sat = (total_count_reg == '1);
    assign count_inc = total_count_reg + COUNT_BITS'(1);
    assign total_sum = SUM_W'(count_inc) + SUM_W'(prod_reg);
    assign total_ovf = ((total_sum >> COUNT_BITS) != '0);

    always_comb
    begin
        phase_next          = phase_reg;
        width_acc_next      = width_acc_reg;
        height_acc_next     = height_acc_reg;
        prod_next           = prod_reg;
        total_count_next    = total_count_reg;
        expected_total_next = expected_total_reg;
        error_code_next     = error_code_reg;

        res             = '0;
        res.done_res    = s_tlast;
        res.status      = ST_OK;

        if (count_sat)
        begin
            if (error_code_next == ST_OK)
            begin
                error_code_next = ST_OVERFLOW;
            end
        end
        else
        begin
            total_count_next = count_inc;
        end

        if (error_code_next == ST_OK)
        begin
            unique case (phase_reg)
                PH_MAGIC_P:
                begin
                    if (in_byte == CH_P) phase_next = PH_MAGIC_4;
                    else                 error_code_next = ST_MAGIC;
                end
                PH_MAGIC_4:
                begin
                    if (in_byte == CH_FOUR) phase_next = PH_MAGIC_NL;
                    else                    error_code_next = ST_MAGIC;
                end
                PH_MAGIC_NL:
                begin
                    if (in_byte == CH_NL) phase_next = PH_LINE_START;
                    else                  error_code_next = ST_MAGIC;
                end
                PH_LINE_START:
                begin
                    priority if (in_byte == CH_HASH)
                    begin
                        phase_next = PH_COMMENT;
                    end
                    else if (is_digit)
                    begin
                        if (width_ovf) error_code_next = ST_OVERFLOW;
                        else           width_acc_next  = width_dig[DIM_BITS-1:0];
                        phase_next = PH_WIDTH;
                    end
                    else if (in_byte == CH_SPACE)
                    begin
                        phase_next = PH_HEIGHT;
                    end
                    else
                    begin
                        error_code_next = ST_SEP;
                    end
                end
                PH_COMMENT:
                begin
                    if (in_byte == CH_NL) phase_next = PH_LINE_START;
                end
                PH_WIDTH:
                begin
                    priority if (is_digit)
                    begin
                        if (width_ovf) error_code_next = ST_OVERFLOW;
                        else           width_acc_next  = width_dig[DIM_BITS-1:0];
                    end
                    else if (in_byte == CH_SPACE)
                    begin
                        phase_next = PH_HEIGHT;
                    end
                    else
                    begin
                        error_code_next = ST_SEP;
                    end
                end
                PH_HEIGHT:
                begin
                    priority if (is_digit)
                    begin
                        if (height_ovf)
                        begin
                            error_code_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            height_acc_next = height_dig[DIM_BITS-1:0];
                            prod_next       = prod_dig[PR_W-1:0];
                        end
                    end
                    else if (in_byte == CH_NL)
                    begin
                        if (total_ovf)
                        begin
                            error_code_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            expected_total_next = total_sum[COUNT_BITS-1:0];
                            phase_next          = PH_DATA;
                        end
                    end
                    else
                    begin
                        error_code_next = ST_SEP;
                    end
                end
                default:
                begin
                    res.pixel_valid = 1'b1;
                    res.pixel_byte  = in_byte;
                end
            endcase
        end

        // Verdict on the last byte of the file
        if (s_tlast)
        begin
            priority if (total_count_next <= COUNT_BITS'(SHORT_LIMIT))
                res.status = ST_SHORT;
            else if (error_code_next != ST_OK)
                res.status = error_code_next;
            else if (phase_next != PH_DATA)
                res.status = ST_TRUNC;
            else if (total_count_next != expected_total_next)
                res.status = ST_MISMATCH;
            else
            begin
                res.status     = ST_OK;
                res.img_width  = IMG_DIM_W'(width_acc_next);
                res.img_height = IMG_DIM_W'(height_acc_next);
            end

            // Drop back to the start of a new file
            phase_next          = PH_MAGIC_P;
            width_acc_next      = '0;
            height_acc_next     = '0;
            prod_next           = '0;
            total_count_next    = '0;
            expected_total_next = '0;
            error_code_next     = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_MAGIC_P;
            width_acc_reg      <= '0;
            height_acc_reg     <= '0;
            prod_reg           <= '0;
            total_count_reg    <= '0;
            expected_total_reg <= '0;
            error_code_reg     <= ST_OK;
        end
        else if (s_accept)
        begin
            phase_reg          <= phase_next;
            width_acc_reg      <= width_acc_next;
            height_acc_reg     <= height_acc_next;
            prod_reg           <= prod_next;
            total_count_reg    <= total_count_next;
            expected_total_reg <= expected_total_next;
            error_code_reg     <= error_code_next;
        end
    end

    // Output register with a skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            // Advance the skid entry first; otherwise load the new word
            out_valid_reg  <= skid_valid_reg || s_accept;
            skid_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            // Receiver stalled: hold the new word in the skid entry
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        if (!out_free && s_accept)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.pixel_valid;
    assign m_tlast  = out_reg.done_res;
    assign m_tdata  = OUT_TDATA_W'({out_reg.img_height, out_reg.img_width,
                                    out_reg.status, out_reg.pixel_byte});

`ifndef SYNTH
    // The skid entry fills only behind a full output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // A last byte always leaves the parser at the start of a new file
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tlast) |=> (phase_reg == PH_MAGIC_P) && (total_count_reg == '0)
                                  && (error_code_reg == ST_OK))
        else $error("parse state not cleared after last byte");

    // A first error sticks until the last byte of the file
    assert property (@(posedge clk) disable iff (!rst_n)
        (error_code_reg != ST_OK) && !(s_accept && s_tlast)
            |=> (error_code_reg == $past(error_code_reg)))
        else $error("error code changed inside a file");

    // Only the last word of a file carries a verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.done_res)
            |-> (out_reg.status == ST_OK) && (out_reg.img_width == '0)
                && (out_reg.img_height == '0))
        else $error("verdict fields set on a word that is not last");
`endif

endmodule

>>> bench/tb_pbm_p4_header_parser_unit.sv
module tb_pbm_p4_header_parser_unit;
    import pbmhp_pkg::*;

    localparam int          DIM_W     = DIM_BITS_DEF;
    localparam int          CNT_W     = COUNT_BITS_DEF;
    localparam logic [63:0] CNT_MAX   = (64'd1 << CNT_W) - 64'd1;
    // Receiver freezes for a long stretch once this many words have arrived
    localparam int          HOLD_AT   = 600;
    localparam int          HOLD_LEN  = 150;
    // Sender waits for a full drain once this many bytes are queued
    localparam int          DRAIN_AT  = 900;
    localparam int          N_BYTES   = 1650;

    // One input word waiting in the sender's queue
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain;   // hold this word until every result is back
    } file_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;    // [7:0] in_byte
    logic                   s_tlast = 1'b0;  // last_byte
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // [7:0] pixel_byte, [10:8] status,
                                             // [26:11] img_width, [42:27] img_height,
                                             // [47:43] zero
    logic                   m_tuser;         // pixel_valid
    logic                   m_tlast;         // done_res

    pbm_p4_header_parser_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Generous ceiling: every byte paying the longest gap on both sides
    initial
    begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Parser model: shadow copy of the header state machine
    // ------------------------------------------------------------------
    phase_t              hdr_phase;
    logic [DIM_W-1:0]    wid_acc;
    logic [DIM_W-1:0]    hgt_acc;
    logic [CNT_W-1:0]    byte_cnt;
    logic [CNT_W-1:0]    total_due;
    status_t             err_code;

    res_t                parsed_q[$];    // predicted output words, oldest first
    int                  words_due = 0;  // parsed_q depth as of the last edge
    int                  n_err = 0;

    // Return to "expect P": start of a new file
    function automatic void restart_parse();
        hdr_phase = PH_MAGIC_P;
        wid_acc   = '0;
        hgt_acc   = '0;
        byte_cnt  = '0;
        total_due = '0;
        err_code  = ST_OK;
    endfunction

    // Keep only the first error of a file
    function automatic void note_error(status_t code);
        if (err_code == ST_OK)
            err_code = code;
    endfunction

    function automatic bit is_dec(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    // Shift in one decimal digit; leave the value alone and flag overflow
    // when it would no longer fit the accumulator
    function automatic logic [DIM_W-1:0] add_digit(logic [DIM_W-1:0] acc, logic [7:0] b);
        logic [DIM_W+3:0] v;
        v = acc * 10 + (b - CH_ZERO);
        if (v[DIM_W+3:DIM_W] != '0)
        begin
            note_error(ST_OVERFLOW);
            return acc;
        end
        return v[DIM_W-1:0];
    endfunction

    // Advance the model by one byte and build the word the block must emit
    function automatic res_t parse_byte(logic [7:0] b, logic last);
        res_t        r;
        logic [63:0] grand;
        r = '0;
        if (byte_cnt == CNT_MAX)
            note_error(ST_OVERFLOW);
        else
            byte_cnt = byte_cnt + 1'b1;

        if (err_code == ST_OK)
        begin
            case (hdr_phase)
                PH_MAGIC_P:
                    if (b == CH_P) hdr_phase = PH_MAGIC_4; else note_error(ST_MAGIC);
                PH_MAGIC_4:
                    if (b == CH_FOUR) hdr_phase = PH_MAGIC_NL; else note_error(ST_MAGIC);
                PH_MAGIC_NL:
                    if (b == CH_NL) hdr_phase = PH_LINE_START; else note_error(ST_MAGIC);
                PH_LINE_START:
                begin
                    // '#' opens a comment only here, at the head of a line
                    if (b == CH_HASH)
                        hdr_phase = PH_COMMENT;
                    else if (is_dec(b))
                    begin
                        wid_acc   = add_digit(wid_acc, b);
                        hdr_phase = PH_WIDTH;
                    end
                    else if (b == CH_SPACE)
                        hdr_phase = PH_HEIGHT;   // width with no digits counts as 0
                    else
                        note_error(ST_SEP);
                end
                PH_COMMENT:
                    if (b == CH_NL) hdr_phase = PH_LINE_START;
                PH_WIDTH:
                begin
                    if (is_dec(b))
                        wid_acc = add_digit(wid_acc, b);
                    else if (b == CH_SPACE)
                        hdr_phase = PH_HEIGHT;
                    else
                        note_error(ST_SEP);
                end
                PH_HEIGHT:
                begin
                    if (is_dec(b))
                        hgt_acc = add_digit(hgt_acc, b);
                    else if (b == CH_NL)
                    begin
                        // Header closed: fix the file length the bitmap must reach
                        grand = byte_cnt + ((wid_acc + 64'd7) / 64'd8) * hgt_acc;
                        if (grand > CNT_MAX)
                            note_error(ST_OVERFLOW);
                        else
                        begin
                            total_due = grand[CNT_W-1:0];
                            hdr_phase = PH_DATA;
                        end
                    end
                    else
                        note_error(ST_SEP);
                end
                default:
                begin
                    r.pixel_valid = 1'b1;
                    r.pixel_byte  = b;
                end
            endcase
        end

        if (last)
        begin
            r.done_res = 1'b1;
            if (byte_cnt <= SHORT_LIMIT)
                r.status = ST_SHORT;
            else if (err_code != ST_OK)
                r.status = err_code;
            else if (hdr_phase != PH_DATA)
                r.status = ST_TRUNC;
            else if (byte_cnt != total_due)
                r.status = ST_MISMATCH;
            else
            begin
                r.status     = ST_OK;
                r.img_width  = wid_acc;
                r.img_height = hgt_acc;
            end
            restart_parse();
        end
        return r;
    endfunction

    function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            n_err++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted byte, check every accepted result
    // ------------------------------------------------------------------
    res_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_parse();
            words_due <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                parsed_q.push_back(parse_byte(s_tdata, s_tlast));
            if (m_tvalid && m_tready)
            begin
                if (parsed_q.size() == 0)
                begin
                    $display("%0t: result word expected none actual %0h", $time, m_tdata);
                    n_err++;
                end
                else
                begin
                    want = parsed_q.pop_front();
                    cmp_field("pixel_valid", want.pixel_valid, m_tuser);
                    cmp_field("pixel_byte",  want.pixel_byte,  m_tdata[7:0]);
                    cmp_field("done_res",    want.done_res,    m_tlast);
                    cmp_field("status",      want.status,      m_tdata[10:8]);
                    cmp_field("img_width",   want.img_width,   m_tdata[26:11]);
                    cmp_field("img_height",  want.img_height,  m_tdata[42:27]);
                    cmp_field("pad",         32'd0,            m_tdata[47:43]);
                end
            end
            // Publish the depth by NBA so the driver reads a settled value
            words_due <= parsed_q.size();
        end
    end

    // ------------------------------------------------------------------
    // Driver: pull words from the pending queue, random gap after each word
    // ------------------------------------------------------------------
    file_word_t pending[$];
    file_word_t next_word;
    int         tx_gap = 0;
    bit         tx_quiet = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            tx_gap   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                // Flip between bursts with no gaps and gappy stretches now and then
                if ($urandom_range(0, 63) == 0)
                    tx_quiet = !tx_quiet;
                tx_gap = tx_quiet ? 0 : $urandom_range(0, 15);
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending.size() != 0 &&
                         (!pending[0].drain || (!s_tvalid && words_due == 0)))
                begin
                    next_word = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_word.data;
                    s_tlast  <= next_word.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall after each word, one long freeze mid-run
    // ------------------------------------------------------------------
    int rx_wait = 0;
    int rx_hold = 0;
    int rx_words = 0;
    bit rx_quiet = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait  = 0;
            rx_hold  = 0;
            rx_words = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                rx_words++;
                if ($urandom_range(0, 63) == 0)
                    rx_quiet = !rx_quiet;
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 15);
                // Freeze long enough that both output entries fill and s_tready drops
                if (rx_words == HOLD_AT)
                    rx_hold = HOLD_LEN;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // File builder
    // ------------------------------------------------------------------
    logic [7:0] file_buf[$];
    int         hdr_len;
    int         n_pushed = 0;

    function automatic void put_byte(logic [7:0] b);
        file_buf.push_back(b);
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endfunction

    // Decimal field; zero sometimes left empty, any value sometimes a leading zero
    function automatic void put_dec(int v);
        if (v == 0 && $urandom_range(0, 3) == 0)
            return;
        if ($urandom_range(0, 7) == 0)
            put_byte(CH_ZERO);
        put_str($sformatf("%0d", v));
    endfunction

    // Well-formed file with random comments, data count off by delta
    function automatic void put_image(int w, int h, int delta);
        int  n;
        byte c;
        put_str("P4\n");
        repeat ($urandom_range(0, 2))
        begin
            put_byte(CH_HASH);
            repeat ($urandom_range(0, 6))
            begin
                c = $urandom_range(0, 255);
                put_byte(c == CH_NL ? CH_HASH : c);
            end
            put_byte(CH_NL);
        end
        put_dec(w);
        put_byte(CH_SPACE);
        put_dec(h);
        put_byte(CH_NL);
        hdr_len = file_buf.size();
        n = (w + 7) / 8 * h + delta;
        if (n > 0)
            repeat (n) put_byte($urandom_range(0, 255));
    endfunction

    // Move the built file into the sender's queue, tlast on its final byte
    function automatic void ship(bit drain);
        file_word_t fw;
        for (int i = 0; i < file_buf.size(); i++)
        begin
            fw.data  = file_buf[i];
            fw.last  = (i == file_buf.size() - 1);
            fw.drain = drain && (i == 0);
            pending.push_back(fw);
        end
        n_pushed += file_buf.size();
        file_buf.delete();
    endfunction

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int  kind;
        int  w;
        int  h;
        int  keep;
        bit  drained;

        drained = 1'b0;

        // Directed files
        put_str("P4\n8 1\n");     put_byte(8'hFF); ship(1'b0);  // smallest good image
        put_byte(8'h00);                           ship(1'b0);  // lone byte: too short
        put_str("P4\n");                           ship(1'b0);  // magic only: too short
        put_str("P5\n1 1\n");     put_byte(8'h00); ship(1'b0);  // wrong magic digit
        put_str("P4\n#\n3#1\n");                   ship(1'b0);  // '#' inside width
        put_str("P4\n2\t2\n");    put_byte(8'h11); ship(1'b0);  // tab separator
        put_str("P4\n#\n \n");                     ship(1'b1);  // empty numbers, drain first
        put_str("P4\n00 5\n");                     ship(1'b0);  // zero width
        put_str("P4\n65535 0\n");                  ship(1'b0);  // widest
        put_str("P4\n0 65535\n");                  ship(1'b0);  // tallest
        put_str("P4\n65536 1\n"); put_byte(8'h00); ship(1'b0);  // width overflow
        put_str("P4\n1 99999\n");                  ship(1'b0);  // height overflow
        put_str("P4\n9 2");                        ship(1'b0);  // header cut short
        put_str("P4\n9 1\n");     put_byte(8'hA5); ship(1'b0);  // one data byte missing
        put_str("P4\n1 1\n");     put_byte(8'h5A); put_byte(8'hC3); ship(1'b0); // one extra

        // Random files, mostly well-formed
        while (n_pushed < N_BYTES)
        begin
            kind = $urandom_range(0, 99);
            w    = $urandom_range(0, 40);
            h    = $urandom_range(0, 6);
            if ($urandom_range(0, 15) == 0)
            begin
                // Extreme dimensions, kept with no data bytes
                if ($urandom_range(0, 1) == 1)
                begin
                    w = $urandom_range(0, 65535);
                    h = 0;
                end
                else
                begin
                    w = 0;
                    h = $urandom_range(0, 65535);
                end
            end

            if (kind < 65)
                put_image(w, h, 0);
            else if (kind < 75)
                put_image(w, h, ($urandom_range(0, 1) == 1) ? 1 : -1);
            else if (kind < 83)
            begin
                // Truncate anywhere: inside the header or inside the data
                put_image(w, h, 0);
                keep = $urandom_range(1, file_buf.size());
                while (file_buf.size() > keep)
                    void'(file_buf.pop_back());
            end
            else if (kind < 89)
            begin
                // Corrupt one header byte
                put_image(w, h, 0);
                file_buf[$urandom_range(0, hdr_len - 1)] = $urandom_range(0, 255);
            end
            else if (kind < 94)
            begin
                put_str("P4\n");
                if ($urandom_range(0, 1) == 1)
                    put_str($sformatf("%0d 1\n", $urandom_range(65536, 999999)));
                else
                    put_str($sformatf("1 %0d\n", $urandom_range(65536, 999999)));
                put_byte($urandom_range(0, 255));
            end
            else
                repeat ($urandom_range(1, 12)) put_byte($urandom_range(0, 255));

            if (!drained && n_pushed >= DRAIN_AT)
            begin
                ship(1'b1);
                drained = 1'b1;
            end
            else
                ship(1'b0);
        end

        // Drain: all bytes taken, then all results back, then a short tail;
        // sample between edges so the driver and monitor updates have settled
        while (pending.size() != 0 || s_tvalid)
            @(negedge clk);
        while (words_due != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);

        if (n_err == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
